>>> src/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg: shared types and constants of the ascii command framer
// Byte codes, register indexes, reset values and stream widths.
// ----------------------------------------------------------------------------
package acf_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned SLOT_W      = 5;

  // configuration channel
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEP      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_SEP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_ON_NL     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HANDLER_ENABLE = 8'd3;

  localparam logic [7:0]  RST_FIELD_SEP      = 8'd32;
  localparam logic [7:0]  RST_COMMAND_SEP    = 8'd59;
  localparam logic        RST_DROP_ON_NL     = 1'b0;
  localparam logic [15:0] RST_HANDLER_ENABLE = 16'h0000;

  // byte codes
  localparam logic [7:0] CHR_NUL   = 8'd0;
  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_LF    = 8'd10;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_PLUS  = 8'd43;
  localparam logic [7:0] CHR_MINUS = 8'd45;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  // magnitude saturates one above the largest positive id
  localparam logic [ID_W-1:0] MAG_SAT = 16'd32768;
  localparam logic [ID_W-1:0] ID_MAX  = 16'd32767;

  // id parser phase
  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_WS     = 5'b00010,
    PH_SIGN   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

endpackage

>>> src/ascii_command_framer_top.sv
// ----------------------------------------------------------------------------
// ascii_command_framer_top: delimited ascii command framer
// Frames received bytes into messages and reports the leading command id
// and its handler slot for each non-empty message.
// ----------------------------------------------------------------------------
//  channel   | dir | payload (lsb first)                       | handshake
//  ----------+-----+-------------------------------------------+------------------------
//  s_axis    | in  | rx_byte[7:0]                              | s_axis_tvalid/tready
//  m_axis    | out | command_id[15:0], handler_slot[20:16], 0s | m_axis_tvalid/tready
//  cfg       | in  | cfg_index_i selects reg, cfg_data_i value | cfg_valid_i/cfg_ready_o
//
//  one byte per cycle sustained while m_axis is not stalled
//  the path is input register -> parser and id accumulator -> result register
//  both stages advance together whenever the result register is free or drained
//  a stalled m_axis holds the result register and then the input register
//  reset clears framing state and loads register defaults; cfg is always ready
module ascii_command_framer_top #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned MAX_HANDLERS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // rx_byte[7:0]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [acf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // command_id[15:0], handler_slot[20:16], zero[23:21]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [acf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [acf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [acf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import acf_pkg::*;

  localparam int unsigned CntW       = $clog2(BUFFER_BYTES);
  localparam int unsigned HandlerLim = (MAX_HANDLERS < 16) ? MAX_HANDLERS : 16;

  // configuration registers
  logic [7:0]  field_sep_q, command_sep_q;
  logic        drop_nl_q;
  logic [15:0] handler_en_q;

  // input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // framing state
  logic [CntW-1:0] count_q, count_d, count_inc;
  phase_e          phase_q, phase_d, phase_eff;
  logic            neg_q, neg_d;
  logic [ID_W-1:0] mag_q, mag_d;

  // result stage
  logic              out_valid_q, out_valid_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  logic            out_free, advance;
  logic            is_space, is_digit, is_sign, is_fs, is_nl, restart;
  logic [19:0]     mag_ext, mag_sum;
  logic [ID_W-1:0] mag_next, id_pos, id_m1, res_id;
  logic [SLOT_W-1:0] res_slot;

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - ID_W - SLOT_W){1'b0}}, out_slot_q, out_id_q};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_sep_q   <= RST_FIELD_SEP;
      command_sep_q <= RST_COMMAND_SEP;
      drop_nl_q     <= RST_DROP_ON_NL;
      handler_en_q  <= RST_HANDLER_ENABLE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FIELD_SEP:      field_sep_q   <= cfg_data_i[7:0];
        REG_COMMAND_SEP:    command_sep_q <= cfg_data_i[7:0];
        REG_DROP_ON_NL:     drop_nl_q     <= cfg_data_i[0];
        REG_HANDLER_ENABLE: handler_en_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // byte classes
  assign is_space = (in_byte_q == CHR_SPACE) || (in_byte_q >= CHR_TAB && in_byte_q <= CHR_CR);
  assign is_digit = (in_byte_q >= CHR_ZERO) && (in_byte_q <= CHR_NINE);
  assign is_sign  = (in_byte_q == CHR_PLUS) || (in_byte_q == CHR_MINUS);
  assign is_fs    = (in_byte_q == field_sep_q);
  assign is_nl    = (in_byte_q == CHR_LF) || (in_byte_q == CHR_CR);

  // decimal accumulate, saturating
  assign mag_ext  = {4'b0, mag_q};
  assign mag_sum  = (mag_ext << 3) + (mag_ext << 1) + {16'b0, in_byte_q[3:0]};
  assign mag_next = (mag_sum > {4'b0, MAG_SAT}) ? MAG_SAT : mag_sum[ID_W-1:0];

  assign count_inc = count_q + 1'b1;

  // result of the message that ends now
  assign id_pos = (mag_q > ID_MAX) ? ID_MAX : mag_q;
  assign id_m1  = id_pos - 16'd1;
  assign res_id = neg_q ? (16'd0 - mag_q) : id_pos;

  always_comb begin
    res_slot = '0;
    if (!neg_q && id_pos >= 16'd1 && id_pos <= 16'(HandlerLim) && handler_en_q[id_m1[3:0]]) begin
      res_slot = id_pos[SLOT_W-1:0];
    end
  end

  // parser and framing
  always_comb begin
    count_d   = count_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    restart   = 1'b0;
    phase_eff = (phase_q == PH_LEAD) ? PH_WS : phase_q;
    if (advance && in_byte_q != CHR_NUL) begin
      if (in_byte_q == command_sep_q) begin
        restart = 1'b1;
      end else begin
        // leading field separators keep the parser in its first phase
        if (!(phase_q == PH_LEAD && is_fs)) begin
          phase_d = phase_eff;
          if (phase_eff != PH_DONE) begin
            if (is_fs) begin
              phase_d = PH_DONE;
            end else if (phase_eff == PH_WS && is_space) begin
              phase_d = PH_WS;
            end else if (phase_eff == PH_WS && is_sign) begin
              neg_d   = (in_byte_q == CHR_MINUS);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              mag_d   = mag_next;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
        count_d = count_inc;
        // overlong message or newline drop
        if (count_inc >= CntW'(BUFFER_BYTES - 1)) restart = 1'b1;
        if (drop_nl_q && !is_fs && is_nl) restart = 1'b1;
      end
    end
    if (restart) begin
      count_d = '0;
      phase_d = PH_LEAD;
      neg_d   = 1'b0;
      mag_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_id_d    = out_id_q;
    out_slot_d  = out_slot_q;
    if (out_free) begin
      out_valid_d = advance && (in_byte_q != CHR_NUL) && (in_byte_q == command_sep_q)
                    && (count_q != '0);
      out_id_d    = res_id;
      out_slot_d  = res_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_id_q   <= out_id_d;
    out_slot_q <= out_slot_d;
  end

endmodule

>>> src/acf_checker.sv
// ----------------------------------------------------------------------------
// acf_checker: port-level checks of the ascii command framer
// Watches the result stream and flags malformed or unstable transactions.
// ----------------------------------------------------------------------------
module acf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [acf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import acf_pkg::*;

  // padding above handler_slot stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:ID_W+SLOT_W] == '0)
    else $error("result padding bits not zero");

  // a registered handler is always the id itself
  a_slot_is_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[ID_W+SLOT_W-1:ID_W] != '0
      |-> m_axis_tdata[ID_W-1:SLOT_W] == '0
          && m_axis_tdata[SLOT_W-1:0] == m_axis_tdata[ID_W+SLOT_W-1:ID_W])
    else $error("handler slot differs from command id");

  // at most sixteen handler slots
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ID_W+SLOT_W-1:ID_W] <= 5'd16)
    else $error("handler slot out of range");

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind ascii_command_framer_top acf_checker u_acf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
